// ===== rtl/ncc_pkg.sv =====
// Shared constants, types and queue entry for the nearest-centroid confusion counter.
// No dependencies.
`default_nettype none
package ncc_pkg;

	localparam int NUM_CLASSES    = 6;
	localparam int SAMPLE_BITS    = 12;
	localparam int COUNT_BITS     = 16;

	localparam int NUM_CFG_REGS   = 6;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 36;
	localparam int ROW_BITS       = 3;
	localparam int WINNER_BITS    = 3;
	localparam int OUT_COUNT_BITS = 16;
	localparam int NUM_AXES       = 3;

	localparam int IDX_BITS    = $clog2(NUM_CLASSES);
	localparam int CENTRE_BITS = NUM_AXES * SAMPLE_BITS;
	localparam int SQ_BITS     = 2 * SAMPLE_BITS;
	localparam int DIST_BITS   = SQ_BITS + 2;
	localparam int NUM_PAIRS   = (NUM_CLASSES + 1) / 2;
	localparam int NUM_CELLS   = NUM_CLASSES * NUM_CLASSES;
	localparam int CELL_BITS   = $clog2(NUM_CELLS);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam int QUEUE_DEPTH = 8;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		CMD_CLASSIFY = 1'b0,
		CMD_CLEAR    = 1'b1
	} ncc_cmd_t;

	typedef struct packed {
		ncc_cmd_t              cmd;
		logic [ROW_BITS-1:0]   row;
		logic [IDX_BITS-1:0]   winner;
	} ncc_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ncc_qstat_t;

endpackage
`default_nettype wire

// ===== rtl/ncc_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module ncc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 36,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ncc_front.sv =====
// Front end: centre registers and the distance / nearest-centre pipeline.
// Depends on ncc_pkg.
`default_nettype none
module ncc_front import ncc_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                      in_take,
	input  wire ncc_cmd_t                  command,
	input  wire logic [SAMPLE_BITS-1:0]    sample_x,
	input  wire logic [SAMPLE_BITS-1:0]    sample_y,
	input  wire logic [SAMPLE_BITS-1:0]    sample_z,
	input  wire logic [ROW_BITS-1:0]       true_class,
	output logic                           push,
	output ncc_item_t                      push_item
);

	logic [CENTRE_BITS-1:0] center_q [NUM_CLASSES];
	logic [SAMPLE_BITS-1:0] smp [NUM_AXES];

	logic [SQ_BITS-1:0]     sq_d   [NUM_CLASSES][NUM_AXES];
	logic [SQ_BITS-1:0]     sq_s1  [NUM_CLASSES][NUM_AXES];
	logic [DIST_BITS-1:0]   dist_s2 [NUM_CLASSES];
	logic [DIST_BITS-1:0]   pdist_d [NUM_PAIRS];
	logic [IDX_BITS-1:0]    pidx_d  [NUM_PAIRS];
	logic [DIST_BITS-1:0]   pdist_s3 [NUM_PAIRS];
	logic [IDX_BITS-1:0]    pidx_s3  [NUM_PAIRS];
	logic [IDX_BITS-1:0]    win_d;

	logic v_s1, v_s2, v_s3, v_s4;
	ncc_cmd_t            cmd_s1, cmd_s2, cmd_s3;
	logic [ROW_BITS-1:0] row_s1, row_s2, row_s3;
	ncc_item_t           item_s4;

	assign smp[0] = sample_x;
	assign smp[1] = sample_y;
	assign smp[2] = sample_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CLASSES; k++) begin
				center_q[k] <= '0;
			end
		end else if (cfg_we && int'(cfg_index) < NUM_CFG_REGS
				&& int'(cfg_index) < NUM_CLASSES) begin
			center_q[cfg_index[IDX_BITS-1:0]] <= CENTRE_BITS'(cfg_data);
		end
	end

	always_comb begin
		logic [SAMPLE_BITS-1:0] c;
		logic [SAMPLE_BITS-1:0] diff;
		for (int k = 0; k < NUM_CLASSES; k++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				c    = center_q[k][a*SAMPLE_BITS +: SAMPLE_BITS];
				diff = (c > smp[a]) ? (c - smp[a]) : (smp[a] - c);
				sq_d[k][a] = SQ_BITS'(diff) * SQ_BITS'(diff);
			end
		end
	end

	// pairwise minimum, lower index kept on a tie
	always_comb begin
		int k0;
		int k1;
		for (int p = 0; p < NUM_PAIRS; p++) begin
			k0 = 2 * p;
			k1 = (2 * p + 1 < NUM_CLASSES) ? 2 * p + 1 : 2 * p;
			if (dist_s2[k1] < dist_s2[k0]) begin
				pdist_d[p] = dist_s2[k1];
				pidx_d[p]  = IDX_BITS'(k1);
			end else begin
				pdist_d[p] = dist_s2[k0];
				pidx_d[p]  = IDX_BITS'(k0);
			end
		end
	end

	always_comb begin
		logic [DIST_BITS-1:0] best;
		best  = pdist_s3[0];
		win_d = pidx_s3[0];
		for (int p = 1; p < NUM_PAIRS; p++) begin
			if (pdist_s3[p] < best) begin
				best  = pdist_s3[p];
				win_d = pidx_s3[p];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= command;
		row_s1 <= true_class;
		sq_s1  <= sq_d;
		cmd_s2 <= cmd_s1;
		row_s2 <= row_s1;
		for (int k = 0; k < NUM_CLASSES; k++) begin
			dist_s2[k] <= DIST_BITS'(sq_s1[k][0]) + DIST_BITS'(sq_s1[k][1])
				+ DIST_BITS'(sq_s1[k][2]);
		end
		cmd_s3   <= cmd_s2;
		row_s3   <= row_s2;
		pdist_s3 <= pdist_d;
		pidx_s3  <= pidx_d;
		item_s4.cmd    <= cmd_s3;
		item_s4.row    <= row_s3;
		item_s4.winner <= win_d;
	end

	assign push      = v_s4;
	assign push_item = item_s4;

endmodule
`default_nettype wire

// ===== rtl/ncc_queue.sv =====
// Short FIFO of classified beats between the front and back ends.
// Depends on ncc_pkg.
`default_nettype none
module ncc_queue import ncc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire ncc_item_t push_item,
	input  wire logic      pop,
	output ncc_item_t      head,
	output ncc_qstat_t     stat
);

	ncc_item_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wptr_q, rptr_q;
	logic [QCNT_BITS-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_BITS'(push) - QCNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_item;
		end
	end

	assign head       = slot_q[rptr_q];
	assign stat.full  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);

endmodule
`default_nettype wire

// ===== rtl/ncc_back.sv =====
// Back end: confusion-count read-modify-write with forwarding, and the output register.
// Depends on ncc_pkg and ncc_ram.
`default_nettype none
module ncc_back import ncc_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ncc_item_t                  head,
	input  wire ncc_qstat_t                 qstat,
	output logic                            pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [WINNER_BITS-1:0]          winner,
	output logic [OUT_COUNT_BITS-1:0]       cell_count
);

	logic                   s1_valid_q;
	ncc_cmd_t               cmd_s1;
	logic                   inrange_s1;
	logic [IDX_BITS-1:0]    win_s1;
	logic [CELL_BITS-1:0]   addr_s1;

	logic                   head_inrange;
	logic [CELL_BITS-1:0]   head_addr;
	logic                   advance;
	logic                   we;
	logic [COUNT_BITS-1:0]  rd_data;
	logic [COUNT_BITS-1:0]  old_cnt;
	logic [COUNT_BITS-1:0]  new_cnt;

	logic                   cell_valid_q [NUM_CELLS];
	logic                   lw_valid_q;
	logic [CELL_BITS-1:0]   lw_addr_q;
	logic [COUNT_BITS-1:0]  lw_data_q;

	logic                   out_valid_q;
	logic [WINNER_BITS-1:0] winner_q;
	logic [OUT_COUNT_BITS-1:0] count_q;

	assign head_inrange = int'(head.row) < NUM_CLASSES;
	assign head_addr    = head_inrange
		? CELL_BITS'(int'(head.row) * NUM_CLASSES + int'(head.winner)) : '0;

	assign advance = s1_valid_q && (!out_valid_q || out_ready);
	assign pop     = !qstat.empty && (!s1_valid_q || advance);
	assign we      = advance && cmd_s1 == CMD_CLASSIFY && inrange_s1;

	ncc_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NUM_CELLS)
	) u_counts (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (new_cnt),
		.re    (pop),
		.raddr (head_addr),
		.rdata (rd_data)
	);

	// the write that lands on the read edge is not seen by the RAM
	always_comb begin
		if (lw_valid_q && lw_addr_q == addr_s1) begin
			old_cnt = lw_data_q;
		end else if (cell_valid_q[addr_s1]) begin
			old_cnt = rd_data;
		end else begin
			old_cnt = '0;
		end
		new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			lw_valid_q  <= 1'b0;
			for (int i = 0; i < NUM_CELLS; i++) begin
				cell_valid_q[i] <= 1'b0;
			end
		end else begin
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance && cmd_s1 == CMD_CLEAR) begin
				lw_valid_q <= 1'b0;
				for (int i = 0; i < NUM_CELLS; i++) begin
					cell_valid_q[i] <= 1'b0;
				end
			end else if (we) begin
				lw_valid_q            <= 1'b1;
				cell_valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1     <= head.cmd;
			inrange_s1 <= head_inrange;
			win_s1     <= head.winner;
			addr_s1    <= head_addr;
		end
		if (we) begin
			lw_addr_q <= addr_s1;
			lw_data_q <= new_cnt;
		end
		if (advance) begin
			winner_q <= (cmd_s1 == CMD_CLEAR) ? '0 : WINNER_BITS'(win_s1);
			count_q  <= (cmd_s1 == CMD_CLEAR || !inrange_s1)
				? '0 : OUT_COUNT_BITS'(new_cnt);
		end
	end

	assign out_valid  = out_valid_q;
	assign winner     = winner_q;
	assign cell_count = count_q;

endmodule
`default_nettype wire

// ===== rtl/nearest_centroid_confusion_counter.sv =====
// Top level of the nearest-centroid confusion counter: input credit, front, queue, back.
// Depends on ncc_pkg, ncc_front, ncc_queue, ncc_back.
`default_nettype none
// Takes one sample beat per clock while in_ready is high and returns one result beat
// per sample, in order. A beat passes the distance pipeline (square, sum, pairwise
// minimum, final minimum), an eight-entry queue and then the counter stage (RAM read,
// update and output register). Input is held off only when eight beats are in flight,
// which the queue depth sets. Counts live in a 36 x 16 RAM with one read and one write
// port; back-to-back hits on one cell are forwarded. A clear beat resets the per-cell
// valid flags rather than the RAM, and reset needs no clearing pass. Centre registers
// may be written any cycle the block is idle; cfg_ready is always high.
module nearest_centroid_confusion_counter import ncc_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      command,
	input  wire logic [SAMPLE_BITS-1:0]    sample_x,
	input  wire logic [SAMPLE_BITS-1:0]    sample_y,
	input  wire logic [SAMPLE_BITS-1:0]    sample_z,
	input  wire logic [ROW_BITS-1:0]       true_class,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [WINNER_BITS-1:0]         winner,
	output logic [OUT_COUNT_BITS-1:0]      cell_count
);

	logic                 in_take;
	logic                 push;
	logic                 pop;
	ncc_item_t            push_item;
	ncc_item_t            head;
	ncc_qstat_t           qstat;
	logic [QCNT_BITS-1:0] credit_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (credit_q != QCNT_BITS'(QUEUE_DEPTH));
	assign in_take   = in_valid && in_ready;

	// beats between input and queue head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + QCNT_BITS'(in_take) - QCNT_BITS'(pop);
		end
	end

	ncc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_take    (in_take),
		.command    (ncc_cmd_t'(command)),
		.sample_x   (sample_x),
		.sample_y   (sample_y),
		.sample_z   (sample_z),
		.true_class (true_class),
		.push       (push),
		.push_item  (push_item)
	);

	ncc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	ncc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.winner     (winner),
		.cell_count (cell_count)
	);

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("in-flight credit above queue depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full || pop)
		else $error("queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue popped while empty");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && winner != '0 |-> cell_count != '0 || int'(winner) < NUM_CLASSES)
		else $error("winner outside class range");
`endif

endmodule
`default_nettype wire

// ===== verif/ncc_checker.sv =====
// Scoreboard for the nearest-centroid confusion counter: mirrors the centre registers and
// the confusion tally, predicts every result beat and compares it field by field on arrival.
// Depends on ncc_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 100ps
module ncc_checker import ncc_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	input  wire logic                      cfg_ready,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                      in_valid,
	input  wire logic                      in_ready,
	input  wire logic                      command,
	input  wire logic [SAMPLE_BITS-1:0]    sample_x,
	input  wire logic [SAMPLE_BITS-1:0]    sample_y,
	input  wire logic [SAMPLE_BITS-1:0]    sample_z,
	input  wire logic [ROW_BITS-1:0]       true_class,
	input  wire logic                      out_valid,
	input  wire logic                      out_ready,
	input  wire logic [WINNER_BITS-1:0]    winner,
	input  wire logic [OUT_COUNT_BITS-1:0] cell_count,
	output int                             failures,
	output int                             outstanding
);
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [WINNER_BITS-1:0]    winner;
		logic [OUT_COUNT_BITS-1:0] count;
	} tally_beat_t;

	logic [CENTRE_BITS-1:0] centres [NUM_CLASSES];
	logic [COUNT_BITS-1:0]  tally [NUM_CLASSES][NUM_CLASSES];
	tally_beat_t            predicted_q [$];
	int                     fail_count = 0;
	int                     pending_beats = 0;

	assign failures    = fail_count;
	assign outstanding = pending_beats;

	// exact squared distance, lowest index kept on a tie
	function automatic logic [WINNER_BITS-1:0] nearest_centre(
		logic [SAMPLE_BITS-1:0] px, py, pz);
		int unsigned            pt [NUM_AXES];
		int unsigned            best_d, d, c, g;
		logic [WINNER_BITS-1:0] best;
		pt[0]  = px;
		pt[1]  = py;
		pt[2]  = pz;
		best   = '0;
		best_d = 0;
		for (int k = 0; k < NUM_CLASSES; k++) begin
			d = 0;
			for (int a = 0; a < NUM_AXES; a++) begin
				c = centres[k][a*SAMPLE_BITS +: SAMPLE_BITS];
				g = (c > pt[a]) ? c - pt[a] : pt[a] - c;
				d += g * g;
			end
			if (k == 0 || d < best_d) begin
				best_d = d;
				best   = WINNER_BITS'(k);
			end
		end
		return best;
	endfunction

	function automatic tally_beat_t tally_sample(ncc_cmd_t cmd,
		logic [SAMPLE_BITS-1:0] px, py, pz, logic [ROW_BITS-1:0] row);
		tally_beat_t r;
		r = '0;
		if (cmd == CMD_CLEAR) begin
			foreach (tally[i, j]) tally[i][j] = '0;
			return r;
		end
		r.winner = nearest_centre(px, py, pz);
		if (row < NUM_CLASSES) begin
			if (tally[row][r.winner] != COUNT_MAX)
				tally[row][r.winner] = tally[row][r.winner] + 1'b1;
			r.count = tally[row][r.winner];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		tally_beat_t want;
		if (!arst_n) begin
			foreach (centres[k]) centres[k] = '0;
			foreach (tally[i, j]) tally[i][j] = '0;
			predicted_q.delete();
		end else begin
			if (out_valid === 1'b1 && out_ready) begin
				if (predicted_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: result beat with none expected: winner %0d count %0d",
							$realtime, winner, cell_count);
				end else begin
					want = predicted_q.pop_front();
					if (winner !== want.winner || cell_count !== want.count) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: expected winner %0d count %0d, got winner %0d count %0d",
								$realtime, want.winner, want.count, winner, cell_count);
					end
				end
			end
			if (cfg_valid && cfg_ready && cfg_index < NUM_CFG_REGS)
				centres[cfg_index] = cfg_data;
			if (in_valid && in_ready)
				predicted_q.push_back(tally_sample(ncc_cmd_t'(command), sample_x, sample_y,
					sample_z, true_class));
		end
		pending_beats = predicted_q.size();
	end

endmodule

// ===== verif/testbench.sv =====
// Testbench top for the nearest-centroid confusion counter: clock, reset, centre programming,
// sample stimulus with bursty sender and stalling receiver, and the final verdict.
// Depends on ncc_pkg, ncc_checker and the block itself.
`timescale 1ns / 100ps
module testbench;
	import ncc_pkg::*;

	localparam int HALF_PERIOD     = 4;
	localparam int RESET_CYCLES    = 5;
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int SAME_CELL_HITS  = 32;
	localparam int BEATS_PER_PHASE = 300;
	localparam int DRAIN_CYCLES    = 16;
	localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
	localparam int ROW_MAX         = (1 << ROW_BITS) - 1;

	typedef enum int {
		SET_EXTREMES,
		SET_CLUSTERS,
		SET_TIES,
		SET_ALL_MAX,
		SET_SCATTER
	} centre_set_kind_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      in_valid = 1'b0;
	ncc_cmd_t                  command = CMD_CLASSIFY;
	logic [SAMPLE_BITS-1:0]    sample_x = '0;
	logic [SAMPLE_BITS-1:0]    sample_y = '0;
	logic [SAMPLE_BITS-1:0]    sample_z = '0;
	logic [ROW_BITS-1:0]       true_class = '0;
	logic                      out_ready = 1'b0;
	logic                      cfg_ready;
	logic                      in_ready;
	logic                      out_valid;
	logic [WINNER_BITS-1:0]    winner;
	logic [OUT_COUNT_BITS-1:0] cell_count;
	int                        failures;
	int                        outstanding;

	int unsigned               cycles = 0;
	int unsigned               rx_tick = 0;
	int unsigned               rx_mode = 0;
	int                        burst_left = 0;
	logic [CENTRE_BITS-1:0]    centre_set [NUM_CFG_REGS];

	nearest_centroid_confusion_counter dut (.*);
	ncc_checker scoreboard (.*);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: redraws its stall mode at random now and again, then drives out_ready in that mode
	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick % 97 == 0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
		0: out_ready <= 1'b1;
		1: out_ready <= 1'($urandom_range(0, 1));
		2: out_ready <= (rx_tick[1:0] == 2'd0);
		default: out_ready <= (rx_tick[4:2] != 3'd7);
		endcase
	end

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic push_sample(ncc_cmd_t cmd, logic [SAMPLE_BITS-1:0] px, py, pz,
		logic [ROW_BITS-1:0] row);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		sample_x   <= px;
		sample_y   <= py;
		sample_z   <= pz;
		true_class <= row;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	initial begin
		centre_set_kind_t        kind;
		int                      v, k;
		int unsigned             pt [NUM_AXES];
		logic [ROW_BITS-1:0]     row;
		pt  = '{0, 0, 0};
		row = '0;
		k   = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// centres at reset value: every sample ties, lowest index wins
		push_sample(CMD_CLASSIFY, '0, '0, '0, ROW_BITS'(0));
		push_sample(CMD_CLASSIFY, '1, '1, '1, ROW_BITS'(NUM_CLASSES - 1));
		push_sample(CMD_CLASSIFY, 12'h555, 12'haaa, 12'h0f0, ROW_BITS'(NUM_CLASSES));
		push_sample(CMD_CLASSIFY, 12'haaa, 12'h555, 12'hf0f, ROW_BITS'(ROW_MAX));
		push_sample(CMD_CLEAR, '1, '1, '1, '1);
		push_sample(CMD_CLASSIFY, 12'h0ff, 12'hf00, 12'h00f, ROW_BITS'(0));

		// hammer one cell back to back
		for (int n = 0; n < SAME_CELL_HITS; n++)
			push_sample(CMD_CLASSIFY, SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
				SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
				SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)), ROW_BITS'(3));
		push_sample(CMD_CLEAR, '0, '0, '0, '0);
		push_sample(CMD_CLASSIFY, '0, '1, '0, ROW_BITS'(3));

		for (int p = SET_EXTREMES; p <= SET_SCATTER; p++) begin
			kind = centre_set_kind_t'(p);
			case (kind)
			SET_EXTREMES: begin
				centre_set = '{36'h000_000_000, 36'hfff_fff_fff, 36'h000_000_fff,
					36'h000_fff_000, 36'hfff_000_000, 36'h800_800_800};
			end
			SET_ALL_MAX: begin
				foreach (centre_set[c]) centre_set[c] = '1;
			end
			SET_SCATTER: begin
				foreach (centre_set[c]) centre_set[c] = CENTRE_BITS'({$urandom, $urandom});
			end
			default: begin
				foreach (centre_set[c])
					for (int a = 0; a < NUM_AXES; a++)
						centre_set[c][a*SAMPLE_BITS +: SAMPLE_BITS] = (kind == SET_TIES) ?
							SAMPLE_BITS'($urandom_range(0, 2) * 2) :
							SAMPLE_BITS'($urandom_range(256, 3839));
			end
			endcase

			// idle before reprogramming; out-of-range indexes go last to catch aliasing
			in_valid <= 1'b0;
			while (outstanding != 0) @(negedge clk);
			for (int idx = 0; idx < (1 << CFG_INDEX_BITS); idx++) begin
				cfg_valid <= 1'b1;
				cfg_index <= CFG_INDEX_BITS'(idx);
				cfg_data  <= (idx < NUM_CFG_REGS) ? centre_set[idx] :
					CFG_DATA_BITS'({$urandom, $urandom});
				@(posedge clk);
				while (!cfg_ready) @(posedge clk);
				@(negedge clk);
			end
			cfg_valid <= 1'b0;

			if (kind == SET_EXTREMES) begin
				for (int c = 0; c < NUM_CFG_REGS; c++)
					push_sample(CMD_CLASSIFY, centre_set[c][0 +: SAMPLE_BITS],
						centre_set[c][SAMPLE_BITS +: SAMPLE_BITS],
						centre_set[c][2*SAMPLE_BITS +: SAMPLE_BITS], ROW_BITS'(c));
				// equidistant from centres 0 and 5
				push_sample(CMD_CLASSIFY, 12'h400, 12'h400, 12'h400, ROW_BITS'(2));
			end

			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				if ($urandom_range(0, 39) == 0) begin
					push_sample(CMD_CLEAR, SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
						SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
						SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
						ROW_BITS'($urandom_range(0, ROW_MAX)));
				end else begin
					// a quarter repeat the last sample to hit one cell back to back
					if (n == 0 || $urandom_range(0, 3) != 0) begin
						k = $urandom_range(0, NUM_CLASSES - 1);
						if ($urandom_range(0, 15) == 0)
							row = ROW_BITS'($urandom_range(NUM_CLASSES, ROW_MAX));
						else if ($urandom_range(0, 3) != 0)
							row = ROW_BITS'(k);
						else
							row = ROW_BITS'($urandom_range(0, NUM_CLASSES - 1));
						for (int a = 0; a < NUM_AXES; a++) begin
							case (kind)
							SET_TIES: v = $urandom_range(0, 4);
							SET_ALL_MAX: v = $urandom_range(0, 1) ? $urandom_range(0, SAMPLE_MAX) :
								($urandom_range(0, 1) ? SAMPLE_MAX : 0);
							default: v = ($urandom_range(0, 3) != 0) ?
								int'(centre_set[k][a*SAMPLE_BITS +: SAMPLE_BITS]) +
								int'($urandom_range(0, 128)) - 64 :
								int'($urandom_range(0, SAMPLE_MAX));
							endcase
							pt[a] = (v < 0) ? 0 : ((v > SAMPLE_MAX) ? SAMPLE_MAX : v);
						end
					end
					push_sample(CMD_CLASSIFY, SAMPLE_BITS'(pt[0]), SAMPLE_BITS'(pt[1]),
						SAMPLE_BITS'(pt[2]), row);
				end
			end
		end

		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0 && outstanding == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ncc_pkg.sv
rtl/ncc_ram.sv
rtl/ncc_front.sv
rtl/ncc_queue.sv
rtl/ncc_back.sv
rtl/nearest_centroid_confusion_counter.sv
verif/ncc_checker.sv
verif/testbench.sv
